### sv/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the bounded list store: operation codes,
// status codes, cell control word and controller states.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int BLS_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_APPEND    = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_AT    = 3'd3,
    MODE_READ_ALL  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // HOLD: keep. PUSH: take left neighbor (cell 0 takes din).
  // LOAD: cell at index win takes din. ROT: shift left inside window,
  // last cell of window takes head. POP: shift left inside window, no refill.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_LOAD,
    CELL_ROT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] din;
  } cell_ctl_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_PASS
  } fsm_state_t;

endpackage

### sv/bounded_list_store.sv
// ----------------------------------------------------------------------------
// bounded_list_store
// Ordered list of signed 32-bit values held in a row of shifting cells.
// Insert front, append, remove front, remove at position, read out all.
// ----------------------------------------------------------------------------
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid/in_ready, in_mode, in_value,       | in
//          | in_position                                 |
//  result  | out_valid/out_ready, out_status,            | out
//          | out_element, out_count, out_final_res       |
//
//  Insert, append, remove front and every error case: result loaded as the
//  item is accepted. Remove at position and read out: accept, then one rotation
//  pass through the cells, one step per stored element, plus any result stalls.
//  The result register lets a new item in during the cycle its result leaves.
//  Reset clears the element count and control; cell contents are not reset.
// ----------------------------------------------------------------------------
module bounded_list_store #(
  parameter int CAPACITY = bls_pkg::BLS_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [bls_pkg::MODE_W-1:0]            in_mode,
  input  logic signed [bls_pkg::DATA_W-1:0]     in_value,
  input  logic [bls_pkg::POS_W-1:0]             in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bls_pkg::STATUS_W-1:0]          out_status,
  output logic signed [bls_pkg::DATA_W-1:0]     out_element,
  output logic [bls_pkg::COUNT_W-1:0]           out_count,
  output logic                                  out_final_res
);
  import bls_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  fsm_state_t               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            step_r, step_nxt;
  logic [CW-1:0]            len_r, len_nxt;
  logic [CW-1:0]            drop_r, drop_nxt;
  logic                     rd_r, rd_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_final_r;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] head;
  logic                     out_free;
  logic                     acc;
  logic                     load_out;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_element;
  logic                     res_final;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [PW-1:0]            pos_m1;
  logic [CW+COUNT_W-1:0]    cnt_wide;
  logic                     emit;
  logic                     go;

  bls_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .win    (count_r),
    .head_o (head)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == FSM_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign pos_ext  = PW'(in_position);
  assign cnt_ext  = PW'(count_r);
  assign pos_m1   = pos_ext - PW'(1);
  assign emit     = rd_r || (step_r == drop_r);
  assign go       = !emit || out_free;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    step_nxt    = step_r;
    len_nxt     = len_r;
    drop_nxt    = drop_r;
    rd_nxt      = rd_r;
    ctl.op      = CELL_HOLD;
    ctl.din     = in_value;
    load_out    = 1'b0;
    res_status  = ST_OK;
    res_element = '0;
    res_final   = 1'b1;

    case (state_r)
      FSM_IDLE: begin
        if (acc) begin
          case (mode_t'(in_mode))
            MODE_INS_FRONT, MODE_APPEND: begin
              load_out = 1'b1;
              if (count_r == CAP_C) begin
                res_status = ST_FULL;
              end else begin
                ctl.op    = (mode_t'(in_mode) == MODE_INS_FRONT) ? CELL_PUSH : CELL_LOAD;
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_DEL_FRONT: begin
              load_out = 1'b1;
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.op      = CELL_POP;
                res_element = head;
                count_nxt   = count_r - CW'(1);
              end
            end
            MODE_DEL_AT: begin
              if (count_r == '0) begin
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                load_out   = 1'b1;
                res_status = ST_BADPOS;
              end else begin
                state_nxt = FSM_PASS;
                step_nxt  = '0;
                len_nxt   = count_r;
                drop_nxt  = pos_m1[CW-1:0];
                rd_nxt    = 1'b0;
              end
            end
            MODE_READ_ALL: begin
              if (count_r == '0) begin
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                state_nxt = FSM_PASS;
                step_nxt  = '0;
                len_nxt   = count_r;
                rd_nxt    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_PASS: begin
        // head leaves each step; it goes back to the window tail unless dropped
        if (go) begin
          if (rd_r || step_r != drop_r) begin
            ctl.op = CELL_ROT;
          end else begin
            ctl.op    = CELL_POP;
            count_nxt = count_r - CW'(1);
          end
          if (emit) begin
            load_out    = 1'b1;
            res_element = head;
            res_final   = rd_r ? (step_r == len_r - CW'(1)) : 1'b1;
          end
          step_nxt = step_r + CW'(1);
          if (step_r == len_r - CW'(1)) state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  assign cnt_wide = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      rd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    drop_r <= drop_nxt;
    if (load_out) begin
      out_status_r  <= res_status;
      out_element_r <= res_element;
      out_count_r   <= cnt_wide[COUNT_W-1:0];
      out_final_r   <= res_final;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_element   = out_element_r;
  assign out_count     = out_count_r;
  assign out_final_res = out_final_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count above capacity");

  a_pass_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_PASS |-> !in_ready)
    else $error("input taken during rotation pass");

  a_nonfinal_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_final_r) |-> state_r == FSM_PASS)
    else $error("non-final result outside read-out pass");

  a_pass_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_PASS && rd_r) |=> $stable(count_r))
    else $error("count changed during read-out");

endmodule

### sv/bls_cell.sv
// ----------------------------------------------------------------------------
// bls_cell
// One storage cell of the list chain. Picks its next value from the left
// neighbor, the right neighbor, the chain head or the insert data.
// ----------------------------------------------------------------------------
module bls_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                                clk,
  input  bls_pkg::cell_ctl_t                  ctl,
  input  logic [CW-1:0]                       win,
  input  logic signed [bls_pkg::DATA_W-1:0]   left_i,
  input  logic signed [bls_pkg::DATA_W-1:0]   right_i,
  input  logic signed [bls_pkg::DATA_W-1:0]   head_i,
  output logic signed [bls_pkg::DATA_W-1:0]   data_o
);
  import bls_pkg::*;

  localparam logic [CW:0] IDX_W  = (CW+1)'(IDX);
  localparam logic [CW:0] IDX_P1 = (CW+1)'(IDX + 1);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [CW:0]              win_ext;

  assign win_ext = {1'b0, win};

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_PUSH: data_nxt = left_i;
      CELL_LOAD: begin
        if (win_ext == IDX_W) data_nxt = ctl.din;
      end
      CELL_ROT: begin
        if (IDX_P1 < win_ext)       data_nxt = right_i;
        else if (IDX_P1 == win_ext) data_nxt = head_i;
      end
      CELL_POP: begin
        if (IDX_P1 < win_ext) data_nxt = right_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### sv/bls_chain.sv
// ----------------------------------------------------------------------------
// bls_chain
// Row of list cells, front element in cell 0. All cells share one control
// word; each sees its neighbors (cell 0: din, last cell: zero) and the head.
// ----------------------------------------------------------------------------
module bls_chain #(
  parameter int CAPACITY = bls_pkg::BLS_CAPACITY,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  bls_pkg::cell_ctl_t                  ctl,
  input  logic [CW-1:0]                       win,
  output logic signed [bls_pkg::DATA_W-1:0]   head_o
);
  import bls_pkg::*;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = ctl.din;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    bls_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .win     (win),
      .left_i  (left_d),
      .right_i (right_d),
      .head_i  (cell_q[0]),
      .data_o  (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_list_store. A queue of operations feeds a
// valid/ready driver with random gaps. An in-bench list tracks the expected
// contents and queues expected results on each accepted transfer. A monitor
// checks every result transfer in order against those expectations.
// ----------------------------------------------------------------------------
module tb;
  import bls_pkg::*;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic signed [DATA_W-1:0]  value;
    logic [POS_W-1:0]          pos;
    int                        gap;
    bit                        drain;
  } list_op_t;

  typedef struct {
    status_t                   st;
    logic signed [DATA_W-1:0]  elem;
    logic [COUNT_W-1:0]        cnt;
    logic                      fin;
  } list_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [MODE_W-1:0]           in_mode = '0;
  logic signed [DATA_W-1:0]    in_value = '0;
  logic [POS_W-1:0]            in_position = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [STATUS_W-1:0]         out_status;
  logic signed [DATA_W-1:0]    out_element;
  logic [COUNT_W-1:0]          out_count;
  logic                        out_final_res;

  list_op_t                    op_queue[$];
  list_op_t                    cur_op;
  list_result_t                due_results[$];
  list_result_t                due;
  logic signed [DATA_W-1:0]    held_vals[$];

  bit                          in_fire;
  bit                          out_fire;
  int                          gap_cnt;
  int                          stall_cnt;
  int                          rx_style = 1;
  int                          errors;
  int                          shadow_cnt;
  int                          op_total;

  bounded_list_store u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_element  (out_element),
    .out_count    (out_count),
    .out_final_res(out_final_res)
  );

  always #4 clk = ~clk;

  function automatic void push_result(status_t st, logic signed [DATA_W-1:0] elem,
                                      logic fin);
    list_result_t r;
    r.st   = st;
    r.elem = elem;
    r.cnt  = COUNT_W'(held_vals.size());
    r.fin  = fin;
    due_results.push_back(r);
  endfunction

  // Update the held list for one accepted operation and queue its results.
  function automatic void apply_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] v,
                                   logic [POS_W-1:0] pos);
    logic signed [DATA_W-1:0] e;
    case (mode)
      MODE_INS_FRONT, MODE_APPEND: begin
        if (held_vals.size() >= BLS_CAPACITY) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          if (mode == MODE_INS_FRONT) held_vals.push_front(v);
          else held_vals.push_back(v);
          push_result(ST_OK, '0, 1'b1);
        end
      end
      MODE_DEL_FRONT: begin
        if (held_vals.size() == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          e = held_vals.pop_front();
          push_result(ST_OK, e, 1'b1);
        end
      end
      MODE_DEL_AT: begin
        // empty check comes before the position check
        if (held_vals.size() == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else if (pos < 1 || pos > held_vals.size()) begin
          push_result(ST_BADPOS, '0, 1'b1);
        end else begin
          e = held_vals[pos - 1];
          held_vals.delete(pos - 1);
          push_result(ST_OK, e, 1'b1);
        end
      end
      MODE_READ_ALL: begin
        if (held_vals.size() == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (held_vals[i]) push_result(ST_OK, held_vals[i], i == held_vals.size() - 1);
        end
      end
      default: ;  // unused modes: no result, list unchanged
    endcase
  endfunction

  // Queue one operation; shadow_cnt follows the element count for picking positions.
  task automatic add_op(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] v,
                        logic [POS_W-1:0] pos, int gap, bit drain);
    list_op_t o;
    o.mode  = mode;
    o.value = v;
    o.pos   = pos;
    o.gap   = gap;
    o.drain = drain;
    op_queue.push_back(o);
    case (mode)
      MODE_INS_FRONT, MODE_APPEND: if (shadow_cnt < BLS_CAPACITY) shadow_cnt++;
      MODE_DEL_FRONT: if (shadow_cnt > 0) shadow_cnt--;
      MODE_DEL_AT: if (shadow_cnt > 0 && pos >= 1 && pos <= shadow_cnt) shadow_cnt--;
      default: ;
    endcase
    if (mode <= MODE_READ_ALL) op_total++;
  endtask

  // Monitor: check result transfers first, then predict for the input transfer.
  always @(posedge clk) begin
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_fire = 1'b1;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: st=%0d el=%0d cnt=%0d fin=%0d",
                     out_status, out_element, out_count, out_final_res);
        end else begin
          due = due_results.pop_front();
          if (out_status !== due.st || out_element !== due.elem ||
              out_count !== due.cnt || out_final_res !== due.fin) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st=%0d el=%0d cnt=%0d fin=%0d, got st=%0d el=%0d cnt=%0d fin=%0d",
                       due.st, due.elem, due.cnt, due.fin,
                       out_status, out_element, out_count, out_final_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        apply_op(in_mode, in_value, in_position);
      end
    end
  end

  // Input driver: idle gap per item, optional hold until all results are back.
  always @(negedge clk) begin : drive_in
    logic nv;
    nv = in_valid;
    if (in_fire) nv = 1'b0;
    if (!nv && rst_n && op_queue.size() != 0) begin
      if (gap_cnt < op_queue[0].gap) begin
        gap_cnt++;
      end else if (!op_queue[0].drain || due_results.size() == 0) begin
        cur_op = op_queue.pop_front();
        in_mode     <= cur_op.mode;
        in_value    <= cur_op.value;
        in_position <= cur_op.pos;
        nv = 1'b1;
        gap_cnt = 0;
      end
    end
    in_valid <= nv;
  end

  // Result side: a fresh stall is drawn after every result transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) rx_style = $urandom_range(0, 2);
        case (rx_style)
          0: stall_cnt = 0;
          1: stall_cnt = $urandom_range(0, 15);
          default: stall_cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 0;
        endcase
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      out_ready <= (stall_cnt == 0);
    end
  end

  initial begin : stimulus
    int bias;
    int gap_style;
    int r;
    int w_ins;
    int w_app;
    int w_del;
    int w_at;
    int w_rd;
    int gap;
    int k;
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0] p;

    // directed part
    add_op(MODE_READ_ALL,  '0, '0, 0, 0);
    add_op(MODE_DEL_FRONT, '0, '0, 0, 0);
    add_op(MODE_DEL_AT,    '0, 8'd3, 2, 0);
    add_op(MODE_APPEND,    32'sh7FFF_FFFF, '0, 0, 0);
    add_op(MODE_INS_FRONT, 32'sh8000_0000, 8'hFF, 0, 0);
    add_op(MODE_APPEND,    -32'sd1, '0, 1, 0);
    add_op(MODE_INS_FRONT, '0, '0, 0, 0);
    add_op(MODE_APPEND,    32'sh5555_5555, '0, 0, 0);
    add_op(MODE_APPEND,    32'shAAAA_AAAA, '0, 0, 0);
    add_op(MODE_READ_ALL,  '0, '0, 0, 0);
    add_op(MODE_DEL_AT,    '0, 8'd0, 0, 0);
    add_op(MODE_DEL_AT,    '0, 8'd7, 3, 0);
    add_op(MODE_DEL_AT,    '0, 8'd255, 0, 0);
    add_op(MODE_DEL_AT,    '0, 8'd6, 0, 0);
    add_op(MODE_DEL_AT,    '0, 8'd1, 0, 0);
    add_op(MODE_DEL_AT,    '0, 8'd2, 0, 0);
    add_op(3'd5, $urandom, 8'd1, 0, 0);
    add_op(3'd6, $urandom, 8'd2, 0, 0);
    add_op(3'd7, $urandom, 8'd3, 0, 0);
    add_op(MODE_DEL_FRONT, '0, '0, 0, 1);
    add_op(MODE_READ_ALL,  '0, '0, 0, 0);
    add_op(MODE_DEL_FRONT, '0, '0, 0, 0);
    add_op(MODE_READ_ALL,  '0, '0, 0, 0);

    // random part in phases: grow, shrink, mixed
    k = 0;
    bias = 0;
    gap_style = 0;
    while (op_total < 250) begin
      if (k % 30 == 0) begin
        bias = (k == 0) ? 0 : $urandom_range(0, 2);
        gap_style = $urandom_range(0, 2);
      end
      case (bias)
        0:       begin w_ins = 35; w_app = 35; w_del = 8;  w_at = 10; w_rd = 8;  end
        1:       begin w_ins = 8;  w_app = 8;  w_del = 35; w_at = 32; w_rd = 12; end
        default: begin w_ins = 20; w_app = 20; w_del = 20; w_at = 22; w_rd = 13; end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_ins) m = MODE_INS_FRONT;
      else if (r < w_ins + w_app) m = MODE_APPEND;
      else if (r < w_ins + w_app + w_del) m = MODE_DEL_FRONT;
      else if (r < w_ins + w_app + w_del + w_at) m = MODE_DEL_AT;
      else if (r < w_ins + w_app + w_del + w_at + w_rd) m = MODE_READ_ALL;
      else m = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 70) p = POS_W'($urandom_range(1, (shadow_cnt > 0) ? shadow_cnt : 1));
      else if (r < 85) p = ($urandom_range(0, 1) != 0) ? POS_W'(shadow_cnt + 1) : '0;
      else p = POS_W'($urandom_range(0, 255));
      case (gap_style)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 15);
        default: gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 0;
      endcase
      add_op(m, $urandom, p, gap, $urandom_range(0, 39) == 0);
      k++;
    end
    add_op(MODE_READ_ALL, '0, '0, 0, 1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### bounded_list_store.f
sv/bls_pkg.sv
sv/bls_cell.sv
sv/bls_chain.sv
sv/bounded_list_store.sv
bench/tb.sv
